>>> hdl/lctmf_pkg.sv
// ----------------------------------------------------------------------------
// Load cell trimmed mean filter: shared package
// Register indexes, reset values, field widths, sequencer states and the
// result record carried on the output channel.
// ----------------------------------------------------------------------------
package lctmf_pkg;

	// Configuration port geometry.
	localparam int unsigned CFG_INDEX_BITS = 4;
	localparam int unsigned CFG_DATA_BITS  = 32;

	// Register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLES_PER_READING = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_SPAN_LIMIT   = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_OFFSET         = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_Q24            = 4'd3;

	// Register and field widths.
	localparam int unsigned SPR_BITS          = 7;
	localparam int unsigned LIMIT_BITS        = 24;
	localparam int unsigned OFFSET_BITS       = 24;
	localparam int unsigned GAIN_BITS         = 32;
	localparam int unsigned MEAN_OUT_BITS     = 24;
	localparam int unsigned WEIGHT_BITS       = 32;
	localparam int unsigned WEIGHT_FRAC_SHIFT = 16;

	// Shortest reading: two samples are trimmed, at least one must remain.
	localparam int unsigned MIN_SAMPLES = 3;

	// Register reset values.
	localparam logic        [SPR_BITS-1:0]    RESET_SAMPLES     = 7'd10;
	localparam logic        [LIMIT_BITS-1:0]  RESET_SPAN_LIMIT  = 24'd200;
	localparam logic signed [OFFSET_BITS-1:0] RESET_ZERO_OFFSET = 24'sd0;
	// -0.095 grams per count in Q8.24, truncated toward zero.
	localparam logic signed [GAIN_BITS-1:0]   RESET_GAIN        = -32'sd1593835;

	// Saturation limits of the weight result.
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = 32'h7FFF_FFFF;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_MIN = 32'h8000_0000;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_STORE = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_SCALE = 6'b100000
	} lctmf_state_t;

	// Which mean the shared divider is working on.
	typedef enum logic {
		PASS_TRIMMED = 1'b0,
		PASS_PLAIN   = 1'b1
	} lctmf_pass_t;

	// One result transaction.
	typedef struct packed {
		logic signed [MEAN_OUT_BITS-1:0] trimmed_mean;
		logic signed [MEAN_OUT_BITS-1:0] plain_mean;
		logic        [MEAN_OUT_BITS-1:0] sample_span;
		logic                            is_stable;
		logic signed [WEIGHT_BITS-1:0]   weight_q8;
		logic                            weight_saturated;
	} lctmf_result_t;

endpackage

>>> hdl/lctmf_channels.sv
// ----------------------------------------------------------------------------
// Load cell trimmed mean filter: channel interfaces
// Valid/ready channels for raw samples in and filtered readings out.
// ----------------------------------------------------------------------------

// Sample channel: one raw converter sample per transaction.
interface lctmf_sample_if #(
	parameter int unsigned SAMPLE_BITS = 24
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink   (input valid, input sample_value, output ready);
endinterface

// Result channel: one finished reading per transaction.
interface lctmf_result_if import lctmf_pkg::*; ();
	logic          valid;
	logic          ready;
	lctmf_result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/load_cell_trimmed_mean_filter_unit.sv
// ----------------------------------------------------------------------------
// Load cell trimmed mean filter
// Accumulates raw samples into readings and reports the trimmed and plain
// means, span, stability flag and saturated net weight of each reading.
// ----------------------------------------------------------------------------
// A sample that does not end a reading only updates the accumulators; ready stays high.
// The closing sample starts the sequence that produces the result: the shared
// restoring divider, one quotient bit a cycle on a DW-bit dividend, with DW =
// SAMPLE_BITS + clog2(MAX_SAMPLES + 1) + 1, is used once for each mean, and
// the multiply and scaling steps follow it.
// Reset clears the accumulators and the result slot and loads register defaults.
module load_cell_trimmed_mean_filter_unit import lctmf_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = 64,
	parameter int unsigned SAMPLE_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	lctmf_sample_if.sink              sample_in,
	lctmf_result_if.source            result_out
);

	// Derived widths.
	localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);      // sample count
	localparam int unsigned SW  = SAMPLE_BITS + CW;              // running sum
	localparam int unsigned DW  = SW + 1;                        // dividend
	localparam int unsigned DCW = $clog2(DW);                    // divider steps
	localparam int unsigned EW  = ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;
	localparam int unsigned PW  = EW + GAIN_BITS;                // product
	localparam int unsigned QW  = PW - WEIGHT_FRAC_SHIFT;        // scaled product
	localparam int unsigned LW  = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

	localparam logic signed [SAMPLE_BITS-1:0] MIN_RESET = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] MAX_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [PW-1:0] TRUNC_BIAS = PW'((64'd1 << WEIGHT_FRAC_SHIFT) - 64'd1);

	// Configuration registers.
	logic        [SPR_BITS-1:0]    spr_q;
	logic        [LIMIT_BITS-1:0]  limit_q;
	logic signed [OFFSET_BITS-1:0] offset_q;
	logic signed [GAIN_BITS-1:0]   gain_q;

	// Sequencer and accumulators.
	lctmf_state_t                  state_q;
	lctmf_pass_t                   pass_q;
	logic        [DCW-1:0]         iter_q;
	logic        [CW-1:0]          count_q;
	logic signed [SW-1:0]          sum_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;

	// Divider and datapath registers.
	logic        [CW-1:0]          divisor_q;
	logic        [CW-1:0]          rem_q;
	logic        [DW-1:0]          quo_q;
	logic                          neg_q;
	logic signed [SAMPLE_BITS-1:0] trimmed_q;
	logic signed [SAMPLE_BITS-1:0] plain_q;
	logic signed [PW-1:0]          prod_q;

	// Result slot.
	logic          out_valid_q;
	lctmf_result_t out_q;

	// Combinational signals.
	logic                          sample_fire;
	logic                          slot_free;
	logic        [CW-1:0]          n_eff;
	logic        [CW-1:0]          count_next;
	logic signed [SW-1:0]          sum_next;
	logic signed [SAMPLE_BITS-1:0] min_next;
	logic signed [SAMPLE_BITS-1:0] max_next;
	logic                          reading_done;
	logic signed [DW-1:0]          dividend;
	logic        [DW-1:0]          dividend_mag;
	logic        [CW-1:0]          divisor_load;
	logic        [CW:0]            rem_shift;
	logic        [CW:0]            trial;
	logic        [DW-1:0]          quo_signed;
	logic signed [EW-1:0]          net_counts;
	logic        [PW-1:0]          biased;
	logic signed [QW-1:0]          scaled;
	logic                          sat_hi;
	logic                          sat_lo;
	logic        [WEIGHT_BITS-1:0] weight;
	logic        [SAMPLE_BITS:0]   span_wide;
	logic        [SAMPLE_BITS-1:0] span;
	logic                          stable;

	// Handshakes.
	assign sample_in.ready   = (state_q == ST_IDLE);
	assign sample_fire       = sample_in.valid && sample_in.ready;
	assign slot_free         = !out_valid_q || result_out.ready;
	assign result_out.valid  = out_valid_q;
	assign result_out.data   = out_q;

	// Reading length, clamped to the supported range.
	always_comb begin
		if (int'(spr_q) < int'(MIN_SAMPLES)) begin
			n_eff = CW'(MIN_SAMPLES);
		end else if (int'(spr_q) > int'(MAX_SAMPLES)) begin
			n_eff = CW'(MAX_SAMPLES);
		end else begin
			n_eff = CW'(spr_q);
		end
	end

	// Accumulator update for the sample on the input channel.
	assign count_next   = count_q + CW'(1);
	assign sum_next     = sum_q + SW'(sample_in.sample_value);
	assign min_next     = (sample_in.sample_value < min_q) ? sample_in.sample_value : min_q;
	assign max_next     = (sample_in.sample_value > max_q) ? sample_in.sample_value : max_q;
	assign reading_done = (count_next >= n_eff);

	// Dividend and divisor for the current pass of the divider.
	always_comb begin
		if (pass_q == PASS_TRIMMED) begin
			dividend     = DW'(sum_q) - DW'(min_q) - DW'(max_q);
			divisor_load = count_q - CW'(2);
		end else begin
			dividend     = DW'(sum_q);
			divisor_load = count_q;
		end
		dividend_mag = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
	end

	// One restoring division step; the sign of trial shows whether it fits.
	assign rem_shift  = {rem_q, quo_q[DW-1]};
	assign trial      = rem_shift - {1'b0, divisor_q};
	assign quo_signed = neg_q ? DW'(-quo_q) : quo_q;

	// Net counts ahead of the gain multiply.
	assign net_counts = EW'(trimmed_q) - EW'(offset_q);

	// Divide the product by 2^16 toward zero, then saturate to 32 bits.
	always_comb begin
		biased = prod_q[PW-1] ? (PW'(prod_q) + TRUNC_BIAS) : PW'(prod_q);
		scaled = QW'(signed'(biased[PW-1:WEIGHT_FRAC_SHIFT]));
		sat_hi = !scaled[QW-1] && (|scaled[QW-2:WEIGHT_BITS-1]);
		sat_lo = scaled[QW-1] && !(&scaled[QW-2:WEIGHT_BITS-1]);
		if (sat_hi) begin
			weight = WEIGHT_MAX;
		end else if (sat_lo) begin
			weight = WEIGHT_MIN;
		end else begin
			weight = scaled[WEIGHT_BITS-1:0];
		end
	end

	// Span and stability of the finished reading.
	assign span_wide = {max_q[SAMPLE_BITS-1], max_q} - {min_q[SAMPLE_BITS-1], min_q};
	assign span      = span_wide[SAMPLE_BITS-1:0];
	assign stable    = (LW'(span) < LW'(limit_q));

	// Configuration writes; unlisted indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q    <= RESET_SAMPLES;
			limit_q  <= RESET_SPAN_LIMIT;
			offset_q <= RESET_ZERO_OFFSET;
			gain_q   <= RESET_GAIN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLES_PER_READING: spr_q    <= cfg_data[SPR_BITS-1:0];
				REG_STABLE_SPAN_LIMIT:   limit_q  <= cfg_data[LIMIT_BITS-1:0];
				REG_ZERO_OFFSET:         offset_q <= signed'(cfg_data[OFFSET_BITS-1:0]);
				REG_GAIN_Q24:            gain_q   <= signed'(cfg_data[GAIN_BITS-1:0]);
				default: begin
				end
			endcase
		end
	end

	// Result slot valid: set as a reading is posted, cleared once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_SCALE) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pass_q      <= PASS_TRIMMED;
			iter_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			min_q       <= MIN_RESET;
			max_q       <= MAX_RESET;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (sample_fire) begin
						count_q <= count_next;
						sum_q   <= sum_next;
						min_q   <= min_next;
						max_q   <= max_next;
						if (reading_done) begin
							pass_q  <= PASS_TRIMMED;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					iter_q  <= DCW'(DW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (iter_q == '0) begin
						state_q <= ST_STORE;
					end else begin
						iter_q <= iter_q - DCW'(1);
					end
				end
				ST_STORE: begin
					if (pass_q == PASS_TRIMMED) begin
						pass_q  <= PASS_PLAIN;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					// Wait for the result slot, then start the next reading afresh.
					if (slot_free) begin
						count_q     <= '0;
						sum_q       <= '0;
						min_q       <= MIN_RESET;
						max_q       <= MAX_RESET;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Divider, means, product and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				quo_q     <= dividend_mag;
				rem_q     <= '0;
				neg_q     <= dividend[DW-1];
				divisor_q <= divisor_load;
			end
			ST_DIV: begin
				quo_q <= {quo_q[DW-2:0], ~trial[CW]};
				rem_q <= trial[CW] ? rem_shift[CW-1:0] : trial[CW-1:0];
			end
			ST_STORE: begin
				if (pass_q == PASS_TRIMMED) begin
					trimmed_q <= signed'(quo_signed[SAMPLE_BITS-1:0]);
				end else begin
					plain_q <= signed'(quo_signed[SAMPLE_BITS-1:0]);
				end
			end
			ST_MUL: begin
				prod_q <= net_counts * gain_q;
			end
			ST_SCALE: begin
				if (slot_free) begin
					out_q.trimmed_mean     <= MEAN_OUT_BITS'(trimmed_q);
					out_q.plain_mean       <= MEAN_OUT_BITS'(plain_q);
					out_q.sample_span      <= MEAN_OUT_BITS'(span);
					out_q.is_stable        <= stable;
					out_q.weight_q8        <= signed'(weight);
					out_q.weight_saturated <= sat_hi || sat_lo;
				end
			end
			default: begin
			end
		endcase
	end

	// A new result always comes with freshly cleared accumulators.
	a_clear_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_out.valid) |-> (count_q == '0 && sum_q == '0 && min_q == MIN_RESET))
		else $error("accumulators not cleared when a result was posted");

	// The closing sample of a reading starts the divider sequence.
	a_done_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_fire && reading_done) |=> (state_q == ST_LOAD))
		else $error("closing sample did not start the divider");

	// The divider never runs with a zero divisor.
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (divisor_q != '0))
		else $error("divider running with a zero divisor");

endmodule
